// ===== rtl/oqpi_pkg.sv =====
// ----------------------------------------------------------------------------
// oqpi_pkg
// Shared types and constants for the ordered point queue with positional
// insert: request and status codes, cell control and default sizes.
// ----------------------------------------------------------------------------
package oqpi_pkg;

  // default sizes
  localparam int DepthDefault      = 16;
  localparam int CoordWidthDefault = 16;

  // fixed field widths of the channels
  localparam int FieldWidth    = 16;
  localparam int ReqWidth      = 2;
  localparam int PosWidth      = 5;
  localparam int CountOutWidth = 5;
  localparam int StatusWidth   = 2;

  // request codes
  typedef enum logic [ReqWidth-1:0] {
    ReqAppend = 2'd0,
    ReqInsert = 2'd1,
    ReqRemove = 2'd2,
    ReqSearch = 2'd3
  } req_kind_t;

  // result status codes
  typedef enum logic [StatusWidth-1:0] {
    StOk    = 2'd0,
    StEmpty = 2'd1,
    StRange = 2'd2,
    StFull  = 2'd3
  } status_t;

  // operation broadcast to every cell
  typedef enum logic [1:0] {
    CellHold   = 2'd0,
    CellInsert = 2'd1,
    CellRemove = 2'd2,
    CellSearch = 2'd3
  } cell_op_t;

  typedef struct packed {
    logic     en;
    cell_op_t op;
  } cell_ctrl_t;

endpackage

// ===== rtl/oqpi_req_if.sv =====
// ----------------------------------------------------------------------------
// oqpi_req_if
// Request channel: valid/ready handshake with the request payload.
// ----------------------------------------------------------------------------
interface oqpi_req_if import oqpi_pkg::*; ();

  logic                         valid;
  logic                         ready;
  logic [ReqWidth-1:0]          req_type;
  logic [PosWidth-1:0]          position;
  logic signed [FieldWidth-1:0] item_x;
  logic signed [FieldWidth-1:0] item_y;

  modport source (output valid, req_type, position, item_x, item_y, input ready);
  modport sink (input valid, req_type, position, item_x, item_y, output ready);

endinterface

// ===== rtl/oqpi_rsp_if.sv =====
// ----------------------------------------------------------------------------
// oqpi_rsp_if
// Response channel: valid/ready handshake with the result payload.
// ----------------------------------------------------------------------------
interface oqpi_rsp_if import oqpi_pkg::*; ();

  logic                         valid;
  logic                         ready;
  logic signed [FieldWidth-1:0] head_x;
  logic signed [FieldWidth-1:0] head_y;
  logic                         found;
  logic [CountOutWidth-1:0]     entry_count;
  logic [StatusWidth-1:0]       status;

  modport source (output valid, head_x, head_y, found, entry_count, status,
                  input ready);
  modport sink (input valid, head_x, head_y, found, entry_count, status,
                output ready);

endinterface

// ===== rtl/oqpi_cell.sv =====
// ----------------------------------------------------------------------------
// oqpi_cell
// One queue slot: holds a point, takes its left neighbor on insert behind
// the insert position, its right neighbor on remove, and compares on search.
// ----------------------------------------------------------------------------
module oqpi_cell import oqpi_pkg::*; #(
  parameter int DEPTH       = DepthDefault,
  parameter int COORD_WIDTH = CoordWidthDefault,
  parameter int IDX         = 0
) (
  input  logic                             clk,
  input  cell_ctrl_t                       ctrl,
  input  logic [$clog2(DEPTH+1)-1:0]       pos,
  input  logic [$clog2(DEPTH+1)-1:0]       count,
  input  logic [2*COORD_WIDTH-1:0]         new_data,
  input  logic [2*COORD_WIDTH-1:0]         left_data,
  input  logic [2*COORD_WIDTH-1:0]         right_data,
  output logic [2*COORD_WIDTH-1:0]         data,
  output logic                             hit
);

  localparam int CntW = $clog2(DEPTH+1);
  localparam logic [CntW-1:0] MyIdx = CntW'(IDX);

  // slot contents
  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      case (ctrl.op)
        CellInsert: begin
          if (pos == MyIdx) begin
            data <= new_data;
          end else if (pos < MyIdx) begin
            data <= left_data;
          end
        end
        CellRemove: data <= right_data;
        default: ;
      endcase
    end
  end

  // search compare, only slots below the count take part
  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      hit <= (ctrl.op == CellSearch) && (MyIdx < count) && (data == new_data);
    end
  end

endmodule

// ===== rtl/ordered_queue_with_positional_insert.sv =====
// ----------------------------------------------------------------------------
// ordered_queue_with_positional_insert
// Ordered queue of signed (x, y) points built as a chain of slot cells:
// append, insert at position, remove head and search, one result per beat.
//
//   channel | dir | payload
//   --------+-----+-------------------------------------------------
//   req     | in  | req_type, position, item_x, item_y
//   rsp     | out | head_x, head_y, found, entry_count, status
//
// One request is taken per cycle while req.ready is high; every slot shifts
// or compares in the cycle the request beat is taken. The result then leaves
// through a result stage (alongside which the per-slot hits are registered)
// and the output register, where the hits are reduced. rst clears the count
// and both stages; slot contents are not cleared. req.ready drops only while
// the result stage is full and the output register is held by rsp.ready low.
// ----------------------------------------------------------------------------
module ordered_queue_with_positional_insert import oqpi_pkg::*; #(
  parameter int DEPTH       = DepthDefault,
  parameter int COORD_WIDTH = CoordWidthDefault
) (
  input  logic        clk,
  input  logic        rst,
  oqpi_req_if.sink    req,
  oqpi_rsp_if.source  rsp
);

  localparam int CntW  = $clog2(DEPTH+1);
  localparam int DataW = 2*COORD_WIDTH;
  localparam int CmpW  = (CntW > PosWidth) ? CntW : PosWidth;

  logic [CntW-1:0]             count;
  logic [CntW-1:0]             count_next;
  logic                        accept;
  logic                        full;
  logic [COORD_WIDTH-1:0]      key_x;
  logic [COORD_WIDTH-1:0]      key_y;
  logic [DataW-1:0]            new_data;
  logic [DataW-1:0]            cell_data [DEPTH];
  logic [DEPTH-1:0]            hits;
  logic [CntW-1:0]             cell_pos;
  cell_op_t                    cell_op;
  cell_ctrl_t                  cell_ctrl;
  status_t                     status_now;
  logic [FieldWidth-1:0]       hx_now;
  logic [FieldWidth-1:0]       hy_now;

  logic                        pend_valid;
  logic                        pend_search;
  logic [FieldWidth-1:0]       pend_hx;
  logic [FieldWidth-1:0]       pend_hy;
  logic [CountOutWidth-1:0]    pend_count;
  status_t                     pend_status;
  logic                        pend_adv;

  logic                        out_valid;
  logic [FieldWidth-1:0]       out_hx;
  logic [FieldWidth-1:0]       out_hy;
  logic                        out_found;
  logic [CountOutWidth-1:0]    out_count;
  status_t                     out_status;

  // handshake
  assign pend_adv  = pend_valid && (!out_valid || rsp.ready);
  assign req.ready = !pend_valid || pend_adv;
  assign accept    = req.valid && req.ready;
  assign full      = (count == CntW'(DEPTH));

  // sign-extend the 16-bit inputs, keep the low COORD_WIDTH bits
  always_comb begin
    for (int i = 0; i < COORD_WIDTH; i++) begin
      key_x[i] = (i < FieldWidth) ? req.item_x[i] : req.item_x[FieldWidth-1];
      key_y[i] = (i < FieldWidth) ? req.item_y[i] : req.item_y[FieldWidth-1];
    end
  end
  assign new_data = {key_x, key_y};

  // request decode: status, cell operation and new count
  always_comb begin
    status_now = StOk;
    cell_op    = CellHold;
    count_next = count;
    cell_pos   = count;
    case (req_kind_t'(req.req_type))
      ReqAppend: begin
        if (full) begin
          status_now = StFull;
        end else begin
          cell_op    = CellInsert;
          count_next = count + CntW'(1);
        end
      end
      ReqInsert: begin
        if (CmpW'(req.position) > CmpW'(count)) begin
          status_now = StRange;
        end else if (full) begin
          status_now = StFull;
        end else begin
          cell_op    = CellInsert;
          cell_pos   = CntW'(req.position);
          count_next = count + CntW'(1);
        end
      end
      ReqRemove: begin
        if (count == '0) begin
          status_now = StEmpty;
        end else begin
          cell_op    = CellRemove;
          count_next = count - CntW'(1);
        end
      end
      default: cell_op = CellSearch;
    endcase
  end

  assign cell_ctrl.en = accept;
  assign cell_ctrl.op = cell_op;

  // head value, sign-extended from COORD_WIDTH to the 16-bit field, zero unless a remove is carried out
  always_comb begin
    for (int i = 0; i < FieldWidth; i++) begin
      hx_now[i] = (i < COORD_WIDTH) ? cell_data[0][COORD_WIDTH + i]
                                    : cell_data[0][DataW-1];
      hy_now[i] = (i < COORD_WIDTH) ? cell_data[0][i]
                                    : cell_data[0][COORD_WIDTH-1];
    end
    if (cell_op != CellRemove) begin
      hx_now = '0;
      hy_now = '0;
    end
  end

  // slot chain
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DataW-1:0] left_data;
    logic [DataW-1:0] right_data;
    if (g == 0) begin : g_first
      assign left_data = new_data;
    end else begin : g_mid_left
      assign left_data = cell_data[g-1];
    end
    if (g == DEPTH-1) begin : g_last
      assign right_data = '0;
    end else begin : g_mid_right
      assign right_data = cell_data[g+1];
    end
    oqpi_cell #(
      .DEPTH       (DEPTH),
      .COORD_WIDTH (COORD_WIDTH),
      .IDX         (g)
    ) u_cell (
      .clk        (clk),
      .ctrl       (cell_ctrl),
      .pos        (cell_pos),
      .count      (count),
      .new_data   (new_data),
      .left_data  (left_data),
      .right_data (right_data),
      .data       (cell_data[g]),
      .hit        (hits[g])
    );
  end

  // entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= count_next;
    end
  end

  // result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (accept) begin
      pend_valid <= 1'b1;
    end else if (pend_adv) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_search <= (cell_op == CellSearch);
      pend_hx     <= hx_now;
      pend_hy     <= hy_now;
      pend_count  <= CountOutWidth'(count_next);
      pend_status <= status_now;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pend_adv) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_adv) begin
      out_hx     <= pend_hx;
      out_hy     <= pend_hy;
      out_found  <= pend_search && (|hits);
      out_count  <= pend_count;
      out_status <= pend_status;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.head_x      = out_hx;
  assign rsp.head_y      = out_hy;
  assign rsp.found       = out_found;
  assign rsp.entry_count = out_count;
  assign rsp.status      = out_status;

`ifndef NO_ASSERTIONS
  // count never goes past the number of slots
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(DEPTH))
    else $error("entry count beyond depth");

  // a remove from a non-empty queue drops the count by one
  a_remove_dec: assert property (@(posedge clk) disable iff (rst)
    accept && (req.req_type == ReqRemove) && (count != '0)
    |=> count == $past(count) - CntW'(1))
    else $error("remove did not decrement count");

  // a failed remove returns a zero head
  a_empty_head: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.status == StEmpty) |-> (rsp.head_x == '0) && (rsp.head_y == '0))
    else $error("nonzero head on empty remove");

  // a held result stage blocks new requests
  a_stall: assert property (@(posedge clk) disable iff (rst)
    pend_valid && !pend_adv |-> !req.ready)
    else $error("request taken while result stage is stuck");
`endif

endmodule

// ===== tb/tb_ordered_queue_with_positional_insert.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ordered_queue_with_positional_insert
// Self-checking bench for the ordered point queue. A shadow copy of the
// queue predicts every result beat; appends, positional inserts, head
// removes and searches are driven under random idling on both channels.
// ----------------------------------------------------------------------------
module tb_ordered_queue_with_positional_insert;
  import oqpi_pkg::*;

  localparam int QueueDepth = DepthDefault;
  localparam int StallLimit = 2000;
  localparam int DrainCycles = 8;

  typedef struct {
    logic signed [FieldWidth-1:0] head_x;
    logic signed [FieldWidth-1:0] head_y;
    logic                         found;
    logic [CountOutWidth-1:0]     entry_count;
    status_t                      status;
  } queue_result_t;

  logic clk;
  logic rst;

  oqpi_req_if req_if ();
  oqpi_rsp_if rsp_if ();

  ordered_queue_with_positional_insert dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  // shadow copy of the queue, head at index 0
  logic signed [FieldWidth-1:0] shadow_x [QueueDepth];
  logic signed [FieldWidth-1:0] shadow_y [QueueDepth];
  int unsigned                  shadow_count;

  queue_result_t pending_results [$];
  int            mismatches;
  int            send_idle_pct;
  int            recv_idle_pct;
  int            stall_cycles;

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // apply one request to the shadow queue and return the result it should give
  function automatic queue_result_t apply_request(req_kind_t kind, logic [PosWidth-1:0] pos,
                                                  logic signed [FieldWidth-1:0] x,
                                                  logic signed [FieldWidth-1:0] y);
    queue_result_t r;
    int unsigned   at;
    r.head_x = '0;
    r.head_y = '0;
    r.found  = 1'b0;
    r.status = StOk;
    case (kind)
      ReqAppend, ReqInsert: begin
        at = (kind == ReqAppend) ? shadow_count : pos;
        // range check wins over the full check
        if (at > shadow_count) begin
          r.status = StRange;
        end else if (shadow_count >= QueueDepth) begin
          r.status = StFull;
        end else begin
          for (int i = shadow_count; i > at; i--) begin
            shadow_x[i] = shadow_x[i-1];
            shadow_y[i] = shadow_y[i-1];
          end
          shadow_x[at] = x;
          shadow_y[at] = y;
          shadow_count++;
        end
      end
      ReqRemove: begin
        if (shadow_count == 0) begin
          r.status = StEmpty;
        end else begin
          r.head_x = shadow_x[0];
          r.head_y = shadow_y[0];
          for (int i = 1; i < shadow_count; i++) begin
            shadow_x[i-1] = shadow_x[i];
            shadow_y[i-1] = shadow_y[i];
          end
          shadow_count--;
        end
      end
      default: begin
        for (int i = 0; i < shadow_count; i++) begin
          if (shadow_x[i] == x && shadow_y[i] == y) r.found = 1'b1;
        end
      end
    endcase
    r.entry_count = shadow_count[CountOutWidth-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  // send one request beat; called and returns at a falling edge
  task automatic send_request(req_kind_t kind, logic [PosWidth-1:0] pos,
                              logic signed [FieldWidth-1:0] x,
                              logic signed [FieldWidth-1:0] y);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk);
    end
    req_if.valid    <= 1'b1;
    req_if.req_type <= kind;
    req_if.position <= pos;
    req_if.item_x   <= x;
    req_if.item_y   <= y;
    do @(posedge clk); while (!req_if.ready);
    pending_results.push_back(apply_request(kind, pos, x, y));
    @(negedge clk);
  endtask

  // coordinate with extremes and small values mixed in to make duplicates
  function automatic logic signed [FieldWidth-1:0] pick_coord();
    case ($urandom_range(9))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2, 3:    return FieldWidth'($urandom_range(3));
      default: return FieldWidth'($urandom_range(16'hffff));
    endcase
  endfunction

  // remove and search on an empty store, insert past the count, first insert
  task automatic test_empty_store();
    send_request(ReqRemove, 5'd0, 16'sh0, 16'sh0);
    send_request(ReqSearch, 5'd0, 16'sh0, 16'sh0);
    send_request(ReqInsert, 5'd1, 16'sh1234, 16'sh4321);
    send_request(ReqInsert, 5'd0, 16'sh8000, 16'sh7fff);
  endtask

  // fill with mixed appends and inserts, then hit the full and range cases
  task automatic test_fill_and_full();
    int k;
    k = 0;
    while (shadow_count < QueueDepth) begin
      case (k % 3)
        0:       send_request(ReqAppend, 5'($urandom_range(31)), 16'sh7fff, 16'sh8000);
        1:       send_request(ReqInsert, 5'd0, pick_coord(), pick_coord());
        default: send_request(ReqInsert, 5'($urandom_range(shadow_count)),
                              pick_coord(), pick_coord());
      endcase
      k++;
    end
    send_request(ReqAppend, 5'd0, 16'sh1111, 16'sh2222);
    send_request(ReqInsert, 5'(shadow_count), 16'sh3333, 16'sh4444);
    send_request(ReqInsert, 5'(shadow_count + 1), 16'sh5555, 16'sh6666);
    send_request(ReqInsert, 5'd31, 16'sh7777, 16'sh0888);
  endtask

  // search for an early stored point and for the tail, a partial match, then a head remove
  task automatic test_search_and_remove();
    send_request(ReqSearch, 5'd0, 16'sh8000, 16'sh7fff);
    send_request(ReqSearch, 5'd0, 16'sh8000, 16'sh7ffe);
    send_request(ReqSearch, 5'd0, shadow_x[shadow_count-1], shadow_y[shadow_count-1]);
    send_request(ReqRemove, 5'd17, 16'sh0, 16'sh0);
  endtask

  // random traffic, alternating stretches that tend to fill and to drain
  task automatic test_random_traffic(int send_pct, int recv_pct, int n_items);
    req_kind_t                    kind;
    logic [PosWidth-1:0]          pos;
    logic signed [FieldWidth-1:0] x;
    logic signed [FieldWidth-1:0] y;
    int                           roll;
    int                           idx;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int i = 0; i < n_items; i++) begin
      roll = $urandom_range(99);
      if (((i / 60) % 2) == 0)
        kind = (roll < 35) ? ReqAppend : (roll < 65) ? ReqInsert :
               (roll < 82) ? ReqRemove : ReqSearch;
      else
        kind = (roll < 15) ? ReqAppend : (roll < 30) ? ReqInsert :
               (roll < 75) ? ReqRemove : ReqSearch;
      if (kind == ReqInsert && $urandom_range(9) != 0)
        pos = 5'($urandom_range(shadow_count));
      else
        pos = 5'($urandom_range(31));
      x = pick_coord();
      y = pick_coord();
      // searches aim at a stored point about half the time, sometimes off by one bit
      if (kind == ReqSearch && shadow_count > 0 && $urandom_range(1) == 1) begin
        idx = $urandom_range(shadow_count - 1);
        x = shadow_x[idx];
        y = shadow_y[idx];
        if ($urandom_range(3) == 0) y = y ^ (16'sh1 << $urandom_range(15));
      end
      send_request(kind, pos, x, y);
    end
  endtask

  // receiver backpressure
  always @(negedge clk) begin
    rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // compare each result beat with the oldest prediction
  always @(posedge clk) begin : check_results
    queue_result_t want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result beat with no request outstanding");
      end else begin
        want = pending_results.pop_front();
        if (rsp_if.head_x !== want.head_x)
          report_mismatch($sformatf("head_x got %0d expected %0d", rsp_if.head_x, want.head_x));
        if (rsp_if.head_y !== want.head_y)
          report_mismatch($sformatf("head_y got %0d expected %0d", rsp_if.head_y, want.head_y));
        if (rsp_if.found !== want.found)
          report_mismatch($sformatf("found got %0b expected %0b", rsp_if.found, want.found));
        if (rsp_if.entry_count !== want.entry_count)
          report_mismatch($sformatf("entry_count got %0d expected %0d",
                                    rsp_if.entry_count, want.entry_count));
        if (rsp_if.status !== want.status)
          report_mismatch($sformatf("status got %0d expected %0d", rsp_if.status, want.status));
      end
    end
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("ordered_queue_with_positional_insert verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // test sequence
  initial begin
    rst             = 1'b1;
    req_if.valid    = 1'b0;
    req_if.req_type = ReqAppend;
    req_if.position = '0;
    req_if.item_x   = '0;
    req_if.item_y   = '0;
    mismatches      = 0;
    shadow_count    = 0;
    send_idle_pct   = 27;
    recv_idle_pct   = 61;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_empty_store();
    test_fill_and_full();
    test_search_and_remove();
    test_random_traffic(27, 61, 480);
    test_random_traffic(61, 27, 480);
    test_random_traffic(0, 0, 490);
    req_if.valid <= 1'b0;

    // drain outstanding results, then let the pipeline settle
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("ordered_queue_with_positional_insert verification clean");
    end else begin
      $display("ordered_queue_with_positional_insert verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/oqpi_pkg.sv
rtl/oqpi_req_if.sv
rtl/oqpi_rsp_if.sv
rtl/oqpi_cell.sv
rtl/ordered_queue_with_positional_insert.sv
tb/tb_ordered_queue_with_positional_insert.sv
